// ===== rtl/core/rational_arith_unit_assert.svh =====
// Assertion macros for the rational arithmetic unit checker.
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH
// Implication checked on every clock unless reset is high.
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked unless reset is high.
`define RAU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/core/rau_pkg.sv =====
// Shared types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
   localparam int OperandWidth = 16;
   localparam int NumWidth     = 33;
   localparam int DenWidth     = 32;
   localparam int MagWidth     = 33;
   localparam int CntWidth     = 6;

   localparam logic [1:0] KindAdd = 2'd0;
   localparam logic [1:0] KindSub = 2'd1;
   localparam logic [1:0] KindMul = 2'd2;
   localparam logic [1:0] KindDiv = 2'd3;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;      // capture operands, multiply step 1
      logic form;      // form raw parts
      logic gcd_init;  // load magnitudes into gcd registers
      logic gcd_step;  // one binary gcd step
      logic div_init;  // start the two divisions
      logic div_step;  // one restoring division bit
      logic finish;    // apply signs, present result
   } rau_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic skip;      // a raw part is zero
      logic gcd_done;
      logic div_done;
   } rau_sts_type;
endpackage

// ===== rtl/core/rau_datapath.sv =====
// Datapath: products, binary gcd and serial division of both parts.
`timescale 1ns / 1ps
module rau_datapath (
   input  logic                                    clock,
   input  rau_pkg::rau_cmd_type                    cmd,
   output rau_pkg::rau_sts_type                    sts,
   input  logic [1:0]                              req_kind,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_a_num,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_a_den,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_b_num,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_b_den,
   output logic signed [rau_pkg::NumWidth-1:0]     rsp_res_num,
   output logic signed [rau_pkg::DenWidth-1:0]     rsp_res_den,
   output logic                                    rsp_zero_den
);
   localparam int W  = rau_pkg::OperandWidth;
   localparam int PW = 2 * W;
   localparam int MW = rau_pkg::MagWidth;
   localparam int CntWidthL = rau_pkg::CntWidth;

   logic [1:0] kind_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [PW-1:0] p0_in, p1_in, p2_in;
   logic signed [rau_pkg::NumWidth-1:0] num_ff;
   logic signed [rau_pkg::DenWidth-1:0] den_ff;
   logic [MW-1:0] gx_ff, gy_ff, nq_ff, dq_ff, nr_ff, dr_ff;
   logic [CntWidthL-1:0] sh_ff;
   logic [CntWidthL-1:0] bit_ff;
   logic signed [rau_pkg::NumWidth-1:0] rnum_ff;
   logic signed [rau_pkg::DenWidth-1:0] rden_ff;
   logic zd_ff;

   // Products chosen by kind; p0 a_num times x, p1 second term, p2 denominator.
   always_comb begin
      case (req_kind)
         rau_pkg::KindMul: begin
            p0_in = PW'(req_a_num * req_b_num);
            p1_in = '0;
            p2_in = PW'(req_a_den * req_b_den);
         end
         rau_pkg::KindDiv: begin
            p0_in = PW'(req_a_num * req_b_den);
            p1_in = '0;
            p2_in = PW'(req_a_den * req_b_num);
         end
         default: begin
            p0_in = PW'(req_a_num * req_b_den);
            p1_in = PW'(req_b_num * req_a_den);
            p2_in = PW'(req_a_den * req_b_den);
         end
      endcase
   end

   logic signed [rau_pkg::NumWidth-1:0] sum_w;
   assign sum_w = (kind_ff == rau_pkg::KindSub)
                  ? rau_pkg::NumWidth'(p0_ff) - rau_pkg::NumWidth'(p1_ff)
                  : rau_pkg::NumWidth'(p0_ff) + rau_pkg::NumWidth'(p1_ff);

   logic [MW-1:0] mag_n, mag_d;
   assign mag_n = num_ff[rau_pkg::NumWidth-1] ? MW'(-num_ff) : MW'(num_ff);
   assign mag_d = den_ff[rau_pkg::DenWidth-1] ? MW'(-$signed({den_ff[31], den_ff}))
                                              : MW'({1'b0, den_ff});

   assign sts.skip     = (num_ff == '0) || (den_ff == '0);
   assign sts.gcd_done = (gy_ff == '0);
   assign sts.div_done = (bit_ff == '0);

   // Gcd, shifted back: divisor for both parts.
   logic [MW-1:0] g_w;
   assign g_w = gx_ff << sh_ff;

   logic [MW:0] ntry, dtry;
   assign ntry = {nr_ff, nq_ff[MW-1]} - {1'b0, g_w};
   assign dtry = {dr_ff, dq_ff[MW-1]} - {1'b0, g_w};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (cmd.form) begin
         num_ff <= sum_w;
         den_ff <= rau_pkg::DenWidth'(p2_ff);
      end
      if (cmd.gcd_init) begin
         gx_ff <= mag_n;
         gy_ff <= mag_d;
         sh_ff <= '0;
      end else if (cmd.gcd_step) begin
         // Stein: strip common twos, then odd-odd subtract.
         if (!gx_ff[0] && !gy_ff[0]) begin
            gx_ff <= gx_ff >> 1;
            gy_ff <= gy_ff >> 1;
            sh_ff <= sh_ff + 1'b1;
         end else if (!gx_ff[0]) begin
            gx_ff <= gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_ff <= gy_ff >> 1;
         end else if (gx_ff >= gy_ff) begin
            gx_ff <= gy_ff;
            gy_ff <= (gx_ff - gy_ff) >> 1;
         end else begin
            gy_ff <= (gy_ff - gx_ff) >> 1;
         end
      end
      if (cmd.div_init) begin
         nq_ff  <= mag_n;
         dq_ff  <= mag_d;
         nr_ff  <= '0;
         dr_ff  <= '0;
         bit_ff <= CntWidthL'(MW);
      end else if (cmd.div_step) begin
         bit_ff <= bit_ff - 1'b1;
         if (!ntry[MW]) begin
            nr_ff <= ntry[MW-1:0];
            nq_ff <= {nq_ff[MW-2:0], 1'b1};
         end else begin
            nr_ff <= {nr_ff[MW-2:0], nq_ff[MW-1]};
            nq_ff <= {nq_ff[MW-2:0], 1'b0};
         end
         if (!dtry[MW]) begin
            dr_ff <= dtry[MW-1:0];
            dq_ff <= {dq_ff[MW-2:0], 1'b1};
         end else begin
            dr_ff <= {dr_ff[MW-2:0], dq_ff[MW-1]};
            dq_ff <= {dq_ff[MW-2:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         zd_ff <= (den_ff == '0);
         if (sts.skip) begin
            rnum_ff <= num_ff;
            rden_ff <= den_ff;
         end else begin
            rnum_ff <= num_ff[rau_pkg::NumWidth-1] ? -$signed(nq_ff) : $signed(nq_ff);
            rden_ff <= den_ff[rau_pkg::DenWidth-1]
                       ? rau_pkg::DenWidth'(-$signed(dq_ff))
                       : rau_pkg::DenWidth'(dq_ff);
         end
      end
   end

   assign rsp_res_num  = rnum_ff;
   assign rsp_res_den  = rden_ff;
   assign rsp_zero_den = zd_ff;
endmodule

// ===== rtl/core/rau_control.sv =====
// Controller: sequences products, gcd and divisions for one transaction.
`timescale 1ns / 1ps
module rau_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output rau_pkg::rau_cmd_type cmd,
   input  rau_pkg::rau_sts_type sts
);
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_FORM = 7'b0000010,
      ST_GINI = 7'b0000100,
      ST_GCD  = 7'b0001000,
      ST_DINI = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic valid_ff, valid_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: if (start) begin
            cmd.load = 1'b1;
            state_in = ST_FORM;
         end
         ST_FORM: begin
            cmd.form = 1'b1;
            state_in = ST_GINI;
         end
         ST_GINI: begin
            if (sts.skip) begin
               state_in = ST_FIN;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (sts.gcd_done) begin
               state_in = ST_DINI;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DINI: begin
            cmd.div_init = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
endmodule

// ===== rtl/core/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit.
//  channel  | handshake           | payload
//  request  | start & !busy       | req_kind, req_a_num, req_a_den, req_b_num, req_b_den
//  response | rsp_valid, 1 cycle  | rsp_res_num, rsp_res_den, rsp_zero_den
// A transaction runs from acceptance to the result edge through products and forming,
// the binary gcd loop and a 33-bit restoring division of both parts.
// A zero raw part skips reduction and goes on to the result.
// busy is high from acceptance until the result strobe; the receiver cannot stall.
// Synchronous active-high reset returns the controller to idle.
`timescale 1ns / 1ps
module rational_arith_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_kind,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_a_num,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_a_den,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_b_num,
   input  logic signed [rau_pkg::OperandWidth-1:0] req_b_den,
   output logic                                    rsp_valid,
   output logic signed [rau_pkg::NumWidth-1:0]     rsp_res_num,
   output logic signed [rau_pkg::DenWidth-1:0]     rsp_res_den,
   output logic                                    rsp_zero_den
);
   rau_pkg::rau_cmd_type cmd;
   rau_pkg::rau_sts_type sts;

   rau_control u_control (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .rsp_valid(rsp_valid), .cmd(cmd), .sts(sts)
   );

   rau_datapath u_datapath (
      .clock(clock), .cmd(cmd), .sts(sts),
      .req_kind(req_kind), .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den),
      .rsp_zero_den(rsp_zero_den)
   );
endmodule

// ===== rtl/core/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, with its bind.
`timescale 1ns / 1ps
`include "rational_arith_unit_assert.svh"
module rau_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic signed [rau_pkg::DenWidth-1:0] rsp_res_den,
   input logic                                rsp_zero_den
);
   `RAU_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised")
   `RAU_ASSERT_IMP(a_valid_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `RAU_ASSERT_NXT(a_valid_pulse, clock, reset, rsp_valid, !rsp_valid, "strobe held")
   `RAU_ASSERT_IMP(a_zero_flag, clock, reset, rsp_valid,
                   rsp_zero_den == (rsp_res_den == '0), "zero flag wrong")
endmodule

bind rational_arith_unit rau_checker u_rau_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_res_den(rsp_res_den), .rsp_zero_den(rsp_zero_den)
);

// ===== dv/rational_arith_unit_test.sv =====
// Self-checking testbench of the rational arithmetic unit: directed table then random traffic.
`timescale 1ns / 1ps
module rational_arith_unit_test;
   typedef struct {
      logic [1:0]                              kind;
      logic signed [rau_pkg::OperandWidth-1:0] a_num;
      logic signed [rau_pkg::OperandWidth-1:0] a_den;
      logic signed [rau_pkg::OperandWidth-1:0] b_num;
      logic signed [rau_pkg::OperandWidth-1:0] b_den;
      bit                                      typed;   // expected result given in the row
      logic signed [rau_pkg::NumWidth-1:0]     num;
      logic signed [rau_pkg::DenWidth-1:0]     den;
      logic                                    zden;
   } stim_row_type;

   typedef struct {
      logic signed [rau_pkg::NumWidth-1:0] num;
      logic signed [rau_pkg::DenWidth-1:0] den;
      logic                                zden;
   } fraction_type;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    start = 1'b0;
   logic                                    busy;
   logic [1:0]                              req_kind = rau_pkg::KindAdd;
   logic signed [rau_pkg::OperandWidth-1:0] req_a_num = '0;
   logic signed [rau_pkg::OperandWidth-1:0] req_a_den = '0;
   logic signed [rau_pkg::OperandWidth-1:0] req_b_num = '0;
   logic signed [rau_pkg::OperandWidth-1:0] req_b_den = '0;
   logic                                    rsp_valid;
   logic signed [rau_pkg::NumWidth-1:0]     rsp_res_num;
   logic signed [rau_pkg::DenWidth-1:0]     rsp_res_den;
   logic                                    rsp_zero_den;

   fraction_type expected_fractions[$];
   int unsigned  fail_count = 0;
   int unsigned  result_count = 0;
   int unsigned  kind_count[4];
   int unsigned  zero_den_count = 0;

   rational_arith_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .rsp_valid(rsp_valid), .rsp_res_num(rsp_res_num),
      .rsp_res_den(rsp_res_den), .rsp_zero_den(rsp_zero_den)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Euclid on magnitudes
   function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // Cross-multiply, wrap to output widths, reduce by the gcd when both parts are non-zero
   function automatic fraction_type reduce_fraction(logic [1:0] kind,
         logic signed [rau_pkg::OperandWidth-1:0] an,
         logic signed [rau_pkg::OperandWidth-1:0] ad,
         logic signed [rau_pkg::OperandWidth-1:0] bn,
         logic signed [rau_pkg::OperandWidth-1:0] bd);
      longint          num_raw;
      longint          den_raw;
      longint unsigned g;
      fraction_type    f;
      case (kind)
         rau_pkg::KindAdd: begin
            num_raw = longint'(an) * bd + longint'(bn) * ad;
            den_raw = longint'(ad) * bd;
         end
         rau_pkg::KindSub: begin
            num_raw = longint'(an) * bd - longint'(bn) * ad;
            den_raw = longint'(ad) * bd;
         end
         rau_pkg::KindMul: begin
            num_raw = longint'(an) * bn;
            den_raw = longint'(ad) * bd;
         end
         default: begin
            num_raw = longint'(an) * bd;
            den_raw = longint'(ad) * bn;
         end
      endcase
      f.num = num_raw[rau_pkg::NumWidth-1:0];
      f.den = den_raw[rau_pkg::DenWidth-1:0];
      num_raw = longint'(f.num);
      den_raw = longint'(f.den);
      if (num_raw != 0 && den_raw != 0) begin
         g = gcd_of(num_raw < 0 ? -num_raw : num_raw, den_raw < 0 ? -den_raw : den_raw);
         num_raw = num_raw < 0 ? -longint'((-num_raw) / g) : longint'(num_raw / g);
         den_raw = den_raw < 0 ? -longint'((-den_raw) / g) : longint'(den_raw / g);
         f.num = num_raw[rau_pkg::NumWidth-1:0];
         f.den = den_raw[rau_pkg::DenWidth-1:0];
      end
      f.zden = (f.den == 0);
      return f;
   endfunction

   // Drive one transaction at the falling edge and wait for acceptance
   task automatic send_fraction_pair(logic [1:0] kind,
         logic signed [rau_pkg::OperandWidth-1:0] an,
         logic signed [rau_pkg::OperandWidth-1:0] ad,
         logic signed [rau_pkg::OperandWidth-1:0] bn,
         logic signed [rau_pkg::OperandWidth-1:0] bd,
         bit typed, fraction_type given, bit keep_start);
      fraction_type f;
      f = reduce_fraction(kind, an, ad, bn, bd);
      if (typed && (f.num !== given.num || f.den !== given.den || f.zden !== given.zden))
         $error("table row disagrees with predictor: kind %0d %0d/%0d %0d/%0d",
                kind, an, ad, bn, bd);
      req_kind  <= kind;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
      expected_fractions.push_back(typed ? given : f);
      kind_count[kind]++;
      @(negedge clock);
      // Drop start for one cycle so the next drive lands in a later time step
      if (!keep_start) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      fraction_type e;
      if (!reset && rsp_valid) begin
         result_count++;
         if (expected_fractions.size() == 0) begin
            $error("unexpected result %0d/%0d", rsp_res_num, rsp_res_den);
            fail_count++;
         end else begin
            e = expected_fractions.pop_front();
            if (rsp_zero_den) zero_den_count++;
            if (rsp_res_num !== e.num) begin
               $error("res_num expected %0d actual %0d", e.num, rsp_res_num);
               fail_count++;
            end
            if (rsp_res_den !== e.den) begin
               $error("res_den expected %0d actual %0d", e.den, rsp_res_den);
               fail_count++;
            end
            if (rsp_zero_den !== e.zden) begin
               $error("zero_den expected %0d actual %0d", e.zden, rsp_zero_den);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      #20ms;
      $display("rational_arith_unit test failed");
      $finish;
   end

   // Directed table: extremes, every kind, zero parts, division by zero
   localparam int Rows = 16;
   stim_row_type stim_table[Rows] = '{
      '{rau_pkg::KindAdd, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1'b1, 33'sd1, 32'sd1, 1'b0},
      '{rau_pkg::KindSub, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1'b1, 33'sd0, 32'sd4, 1'b0},
      '{rau_pkg::KindMul, 16'sd0, 16'sd3, 16'sd5, 16'sd4, 1'b1, 33'sd0, 32'sd12, 1'b0},
      '{rau_pkg::KindDiv, 16'sd5, 16'sd1, 16'sd0, 16'sd1, 1'b1, 33'sd5, 32'sd0, 1'b1},
      '{rau_pkg::KindMul, 16'sd5, 16'sd0, 16'sd1, 16'sd1, 1'b1, 33'sd5, 32'sd0, 1'b1},
      '{rau_pkg::KindAdd, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
        1'b1, 33'sd2, 32'sd1, 1'b0},
      '{rau_pkg::KindSub, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0, 0, 0, 0},
      '{rau_pkg::KindAdd, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b0, 0, 0, 0},
      '{rau_pkg::KindMul, -16'sd32768, 16'sd1, -16'sd32768, 16'sd1,
        1'b1, 33'sd1073741824, 32'sd1, 1'b0},
      '{rau_pkg::KindDiv, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
        1'b1, -33'sd1, -32'sd1, 1'b0},
      '{rau_pkg::KindMul, -16'sd3, 16'sd4, 16'sd2, 16'sd9, 1'b1, -33'sd1, 32'sd6, 1'b0},
      '{rau_pkg::KindDiv, 16'sd1, -16'sd2, 16'sd1, 16'sd2, 1'b1, 33'sd1, -32'sd1, 1'b0},
      '{rau_pkg::KindAdd, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, 0, 0, 0},
      '{rau_pkg::KindSub, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 33'sd0, 32'sd0, 1'b1},
      '{rau_pkg::KindDiv, 16'sd32767, 16'sd1, 16'sd1, 16'sd32767, 1'b0, 0, 0, 0},
      '{rau_pkg::KindMul, 16'sh5555, -16'sh5556, 16'shAAAA, 16'sh2AAB, 1'b0, 0, 0, 0}
   };

   function automatic logic signed [rau_pkg::OperandWidth-1:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return rau_pkg::OperandWidth'($urandom_range(0, 3));
         1: return rau_pkg::OperandWidth'(-$urandom_range(1, 3));
         2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         3: return rau_pkg::OperandWidth'($urandom_range(1, 60) * $urandom_range(1, 60));
         default: return rau_pkg::OperandWidth'($urandom);
      endcase
   endfunction

   initial begin
      fraction_type f;
      int           burst;
      int           drain;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < Rows; r++) begin
         f.num = stim_table[r].num;
         f.den = stim_table[r].den;
         f.zden = stim_table[r].zden;
         send_fraction_pair(stim_table[r].kind, stim_table[r].a_num, stim_table[r].a_den,
                            stim_table[r].b_num, stim_table[r].b_den,
                            stim_table[r].typed, f, 1'b0);
      end

      // Random bursts with gaps; one pause lets everything drain
      for (int n = 0; n < 1400; ) begin
         burst = $urandom_range(1, 30);
         for (int k = 0; k < burst && n < 1400; k++, n++)
            send_fraction_pair(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                               rand_operand(), rand_operand(), 1'b0, f,
                               k + 1 < burst && n + 1 < 1400);
         if (n >= 700 && n < 700 + burst) begin
            drain = 0;
            while (expected_fractions.size() != 0 && drain < 1000) begin
               @(negedge clock);
               drain++;
            end
         end
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 150)) @(negedge clock);
      end

      drain = 0;
      while (expected_fractions.size() != 0 && drain < 1000) begin
         @(negedge clock);
         drain++;
      end
      repeat (150) @(negedge clock);
      if (expected_fractions.size() != 0) begin
         $error("%0d results never arrived", expected_fractions.size());
         fail_count++;
      end
      $display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d; %0d with zero den.",
               result_count, kind_count[rau_pkg::KindAdd], kind_count[rau_pkg::KindSub],
               kind_count[rau_pkg::KindMul], kind_count[rau_pkg::KindDiv], zero_den_count);
      if (fail_count == 0)
         $display("rational_arith_unit test passed");
      else
         $display("rational_arith_unit test failed");
      $finish;
   end
endmodule
